// ===== rtl/glyph_block_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph block matcher assertion macros
// Shared assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLOCK_MATCHER_DEFINES_SVH
`define GLYPH_BLOCK_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define GBM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("glyph_block_matcher: invariant violated");
`define GBM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph_block_matcher: implication violated");
`define GBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph_block_matcher: sequence violated");
`else
`define GBM_ASSERT_ALWAYS(label, expr)
`define GBM_ASSERT_IMPLIES(label, ante, cons)
`define GBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/gbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph block matcher package
// Word types, glyph mask ROM and UTF-8 encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbm_pkg;

    localparam int GLYPH_COUNT = 51;
    localparam int ROM_SIZE    = 51;
    localparam int GLYPH_LIMIT = (GLYPH_COUNT > ROM_SIZE) ? ROM_SIZE : GLYPH_COUNT;
    localparam int CELL_PIXELS = 32;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [20:0] glyph_codepoint;
        logic [31:0] utf8_bytes;
        logic [2:0]  utf8_length;
        logic [23:0] clear_color;
        logic [23:0] ink_color;
        logic [22:0] match_error;
    } result_t;

    function automatic logic [31:0] glyph_mask(input logic [5:0] idx);
        logic [31:0] m;
        case (idx)
            6'd0:  m = 32'h00000000;
            6'd1:  m = 32'h0000000f;
            6'd2:  m = 32'h000000ff;
            6'd3:  m = 32'h00000fff;
            6'd4:  m = 32'h0000ffff;
            6'd5:  m = 32'h000fffff;
            6'd6:  m = 32'h00ffffff;
            6'd7:  m = 32'h0fffffff;
            6'd8:  m = 32'heeeeeeee;
            6'd9:  m = 32'hcccccccc;
            6'd10: m = 32'h88888888;
            6'd11: m = 32'h0000cccc;
            6'd12: m = 32'h00003333;
            6'd13: m = 32'hcccc0000;
            6'd14: m = 32'hcccc3333;
            6'd15: m = 32'h33330000;
            6'd16: m = 32'h000ff000;
            6'd17: m = 32'h66666666;
            6'd18: m = 32'h00077666;
            6'd19: m = 32'h000ee666;
            6'd20: m = 32'h66677000;
            6'd21: m = 32'h666ee000;
            6'd22: m = 32'h66677666;
            6'd23: m = 32'h666ee666;
            6'd24: m = 32'h000ff666;
            6'd25: m = 32'h666ff000;
            6'd26: m = 32'h666ff666;
            6'd27: m = 32'h000cc000;
            6'd28: m = 32'h00066000;
            6'd29: m = 32'h00033000;
            6'd30: m = 32'h00066000;
            6'd31: m = 32'h06600660;
            6'd32: m = 32'h000f0000;
            6'd33: m = 32'h0000f000;
            6'd34: m = 32'h44444444;
            6'd35: m = 32'h22222222;
            6'd36: m = 32'h000e0000;
            6'd37: m = 32'h0000e000;
            6'd38: m = 32'h44440000;
            6'd39: m = 32'h22220000;
            6'd40: m = 32'h00030000;
            6'd41: m = 32'h00003000;
            6'd42: m = 32'h00004444;
            6'd43: m = 32'h00002222;
            6'd44: m = 32'h44444444;
            6'd45: m = 32'h22222222;
            6'd46: m = 32'h0f000000;
            6'd47: m = 32'h00f00000;
            6'd48: m = 32'h00000f00;
            6'd49: m = 32'h000000f0;
            6'd50: m = 32'h00066000;
            default: m = 32'h00000000;
        endcase
        return m;
    endfunction

    function automatic logic [20:0] glyph_code(input logic [5:0] idx);
        logic [20:0] c;
        case (idx)
            6'd0:  c = 21'h000a0;
            6'd1:  c = 21'h02581;
            6'd2:  c = 21'h02582;
            6'd3:  c = 21'h02583;
            6'd4:  c = 21'h02584;
            6'd5:  c = 21'h02585;
            6'd6:  c = 21'h02586;
            6'd7:  c = 21'h02587;
            6'd8:  c = 21'h0258a;
            6'd9:  c = 21'h0258c;
            6'd10: c = 21'h0258e;
            6'd11: c = 21'h02596;
            6'd12: c = 21'h02597;
            6'd13: c = 21'h02598;
            6'd14: c = 21'h0259a;
            6'd15: c = 21'h0259d;
            6'd16: c = 21'h02501;
            6'd17: c = 21'h02503;
            6'd18: c = 21'h0250f;
            6'd19: c = 21'h02513;
            6'd20: c = 21'h02517;
            6'd21: c = 21'h0251b;
            6'd22: c = 21'h02523;
            6'd23: c = 21'h0252b;
            6'd24: c = 21'h02533;
            6'd25: c = 21'h0253b;
            6'd26: c = 21'h0254b;
            6'd27: c = 21'h02578;
            6'd28: c = 21'h02579;
            6'd29: c = 21'h0257a;
            6'd30: c = 21'h0257b;
            6'd31: c = 21'h0254f;
            6'd32: c = 21'h02500;
            6'd33: c = 21'h02500;
            6'd34: c = 21'h02502;
            6'd35: c = 21'h02502;
            6'd36: c = 21'h02574;
            6'd37: c = 21'h02574;
            6'd38: c = 21'h02575;
            6'd39: c = 21'h02575;
            6'd40: c = 21'h02576;
            6'd41: c = 21'h02576;
            6'd42: c = 21'h02577;
            6'd43: c = 21'h02577;
            6'd44: c = 21'h023a2;
            6'd45: c = 21'h023a5;
            6'd46: c = 21'h023ba;
            6'd47: c = 21'h023bb;
            6'd48: c = 21'h023bc;
            6'd49: c = 21'h023bd;
            6'd50: c = 21'h025aa;
            default: c = 21'h00000;
        endcase
        return c;
    endfunction

    // Right-aligned UTF-8 encoding; the low three bits of the result are the length.
    function automatic logic [34:0] utf8_encode(input logic [20:0] cp);
        logic [31:0] b;
        logic [2:0]  n;
        if (cp <= 21'h7f) begin
            b = {25'd0, cp[6:0]};
            n = 3'd1;
        end else if (cp <= 21'h7ff) begin
            b = {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            n = 3'd2;
        end else if (cp <= 21'hffff) begin
            b = {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            n = 3'd3;
        end else begin
            b = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
            n = 3'd4;
        end
        return {b, n};
    endfunction

endpackage

// ===== rtl/glyph_block_matcher.sv =====
// ----------------------------------------------------------------------------
// Glyph block matcher
// Collects one 4x8 cell of RGB pixels and finds the best two-color glyph.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  pixel    | in        | start && !busy     | gbm_pkg::pixel_t
//  result   | out       | done (one cycle)   | gbm_pkg::result_t
//
//  A pixel is taken whenever start is high and busy is low; the 32nd pixel starts the search.
//  Each glyph passes through the sum, divide, error and compare states; the
//  sum and error states read through the single read port of the pixel memory.
//  After all 51 glyphs an output state follows, and busy falls as done rises.
//  Reset clears the control state; the pixel memory is written before it is read.
//  The receiver cannot stall; done is high for exactly one cycle.
`timescale 1ns / 1ps
`include "glyph_block_matcher_defines.svh"

module glyph_block_matcher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gbm_pkg::pixel_t  pixel,
    output logic             busy,
    output logic             done,
    output gbm_pkg::result_t result
);
    import gbm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [5:0] LAST_GLYPH = 6'(GLYPH_LIMIT - 1);

    logic [23:0] pixel_mem [CELL_PIXELS];
    logic [23:0] rd_data_reg;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  pix_cnt_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  step_reg;
    logic [5:0]  glyph_reg;
    logic        rd_vld_reg;
    logic [4:0]  rd_idx_reg;
    logic        rd_en;
    logic [4:0]  rd_addr;

    logic [12:0] sum_reg [6];
    logic [5:0]  ink_cnt_reg;
    logic [5:0]  clear_cnt;
    logic [12:0] div_reg [6];
    logic [6:0]  rem_reg [6];
    logic [12:0] div_next [6];
    logic [6:0]  rem_next [6];

    logic [15:0] sq_reg [3];
    logic        sq_vld_reg;
    logic [22:0] err_reg;

    logic [22:0] best_err_reg;
    logic [5:0]  best_glyph_reg;
    logic [23:0] best_clear_reg;
    logic [23:0] best_ink_reg;

    logic [31:0] mask;
    logic        rd_bit;
    logic [23:0] col_clear, col_ink, col_sel;
    logic [34:0] enc;
    logic [20:0] best_code;

    logic        accept;
    result_t     result_reg;
    logic        done_reg;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign mask      = glyph_mask(glyph_reg);
    assign rd_bit    = mask[5'd31 - rd_idx_reg];
    assign clear_cnt = 6'd32 - ink_cnt_reg;
    assign rd_en     = ((state_reg == S_SUM) || (state_reg == S_ERR)) && !cnt_reg[5];
    assign rd_addr   = cnt_reg[4:0];

    // An empty group renders as black.
    assign col_clear = (clear_cnt == 6'd0) ? 24'd0
                     : {div_reg[0][7:0], div_reg[1][7:0], div_reg[2][7:0]};
    assign col_ink   = (ink_cnt_reg == 6'd0) ? 24'd0
                     : {div_reg[3][7:0], div_reg[4][7:0], div_reg[5][7:0]};
    assign col_sel   = rd_bit ? col_ink : col_clear;

    assign best_code = glyph_code(best_glyph_reg);
    assign enc       = utf8_encode(best_code);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_mem[pix_cnt_reg] <= pixel;
        end
        if (rd_en)
        begin
            rd_data_reg <= pixel_mem[rd_addr];
        end
    end

    // Six restoring dividers, one quotient bit per cycle each.
    always_comb
    begin
        logic [6:0] rsh;
        logic [6:0] dvs;
        for (int i = 0; i < 6; i++)
        begin
            dvs = (i < 3) ? {1'b0, clear_cnt} : {1'b0, ink_cnt_reg};
            rsh = {rem_reg[i][5:0], div_reg[i][12]};
            if (rsh >= dvs)
            begin
                rem_next[i] = rsh - dvs;
                div_next[i] = {div_reg[i][11:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rsh;
                div_next[i] = {div_reg[i][11:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = 6'd0;
                if (accept && pix_cnt_reg == 5'd31)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cnt_next = cnt_reg + 6'd1;
                // The count runs past the last read so that the final sum settles.
                if (cnt_reg == 6'd33)
                begin
                    state_next = S_DIV;
                    cnt_next   = 6'd0;
                end
            end
            S_DIV:
            begin
                if (step_reg == 4'd12)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd33)
                begin
                    state_next = S_CMP;
                    cnt_next   = 6'd0;
                end
            end
            S_CMP:
            begin
                state_next = (glyph_reg == LAST_GLYPH) ? S_OUT : S_SUM;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pix_cnt_reg    <= 5'd0;
            cnt_reg        <= 6'd0;
            step_reg       <= 4'd0;
            glyph_reg      <= 6'd0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= 5'd0;
            sq_vld_reg     <= 1'b0;
            ink_cnt_reg    <= 6'd0;
            err_reg        <= 23'd0;
            best_err_reg   <= '1;
            best_glyph_reg <= 6'd0;
            best_clear_reg <= 24'd0;
            best_ink_reg   <= 24'd0;
            done_reg       <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                sum_reg[i] <= 13'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_en;
            rd_idx_reg <= rd_addr;
            done_reg   <= 1'b0;

            if (accept)
            begin
                pix_cnt_reg <= pix_cnt_reg + 5'd1;
            end

            if (state_reg == S_IDLE && state_next == S_SUM)
            begin
                glyph_reg      <= 6'd0;
                best_err_reg   <= '1;
                best_glyph_reg <= 6'd0;
                best_clear_reg <= 24'd0;
                best_ink_reg   <= 24'd0;
            end

            // Group sums start fresh at the first read of each glyph.
            if (state_reg == S_SUM && cnt_reg == 6'd0)
            begin
                ink_cnt_reg <= 6'd0;
                for (int i = 0; i < 6; i++)
                begin
                    sum_reg[i] <= 13'd0;
                end
            end
            else if (state_reg == S_SUM && rd_vld_reg)
            begin
                if (rd_bit)
                begin
                    ink_cnt_reg <= ink_cnt_reg + 6'd1;
                    sum_reg[3]  <= sum_reg[3] + 13'(rd_data_reg[23:16]);
                    sum_reg[4]  <= sum_reg[4] + 13'(rd_data_reg[15:8]);
                    sum_reg[5]  <= sum_reg[5] + 13'(rd_data_reg[7:0]);
                end
                else
                begin
                    sum_reg[0]  <= sum_reg[0] + 13'(rd_data_reg[23:16]);
                    sum_reg[1]  <= sum_reg[1] + 13'(rd_data_reg[15:8]);
                    sum_reg[2]  <= sum_reg[2] + 13'(rd_data_reg[7:0]);
                end
            end

            if (state_reg == S_SUM && state_next == S_DIV)
            begin
                step_reg <= 4'd0;
            end
            else if (state_reg == S_DIV)
            begin
                step_reg <= step_reg + 4'd1;
            end

            sq_vld_reg <= (state_reg == S_ERR) && rd_vld_reg;
            if (state_reg == S_ERR && cnt_reg == 6'd0)
            begin
                err_reg <= 23'd0;
            end
            else if (sq_vld_reg)
            begin
                err_reg <= err_reg + 23'(sq_reg[0]) + 23'(sq_reg[1]) + 23'(sq_reg[2]);
            end

            if (state_reg == S_CMP)
            begin
                if (err_reg < best_err_reg)
                begin
                    best_err_reg   <= err_reg;
                    best_glyph_reg <= glyph_reg;
                    best_clear_reg <= col_clear;
                    best_ink_reg   <= col_ink;
                end
                glyph_reg <= glyph_reg + 6'd1;
            end

            if (state_reg == S_OUT)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        logic [7:0] d;
        for (int c = 0; c < 3; c++)
        begin
            d = (col_sel[c*8 +: 8] > rd_data_reg[c*8 +: 8])
              ? col_sel[c*8 +: 8] - rd_data_reg[c*8 +: 8]
              : rd_data_reg[c*8 +: 8] - col_sel[c*8 +: 8];
            sq_reg[2 - c] <= {8'd0, d} * {8'd0, d};
        end
        if (state_reg == S_SUM && state_next == S_DIV)
        begin
            for (int i = 0; i < 6; i++)
            begin
                div_reg[i] <= sum_reg[i];
                rem_reg[i] <= 7'd0;
            end
        end
        else if (state_reg == S_DIV)
        begin
            for (int i = 0; i < 6; i++)
            begin
                div_reg[i] <= div_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        if (state_reg == S_OUT)
        begin
            result_reg.glyph_codepoint <= best_code;
            result_reg.utf8_bytes      <= enc[34:3];
            result_reg.utf8_length     <= enc[2:0];
            result_reg.clear_color     <= best_clear_reg;
            result_reg.ink_color       <= best_ink_reg;
            result_reg.match_error     <= best_err_reg;
        end
    end

    `GBM_ASSERT_IMPLIES(a_done_idle, done, !busy)
    `GBM_ASSERT_NEXT(a_last_pixel_starts, accept && pix_cnt_reg == 5'd31, busy)
    `GBM_ASSERT_ALWAYS(a_ink_count_bound, ink_cnt_reg <= 6'd32)
    `GBM_ASSERT_IMPLIES(a_glyph_bound, busy && state_reg != S_OUT,
                        glyph_reg <= LAST_GLYPH)

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Glyph block matcher testbench
// Streams cells of RGB pixels into the matcher and checks every result word
// against a predictor that scores all glyph masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int CELLS_RANDOM = 42;
    localparam int MASK_COUNT = 51;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    gbm_pkg::pixel_t     pixel = '0;
    logic                busy;
    logic                done;
    gbm_pkg::result_t    result;

    gbm_pkg::result_t    pending_results[$];
    logic [23:0]         cell_pixels[32];
    int                  cell_fill = 0;
    int                  error_count = 0;
    int                  pixels_sent = 0;
    int                  results_seen = 0;
    int                  idle_cycles = 0;
    bit                  gaps_on = 1'b1;

    logic [31:0] mask_rom[MASK_COUNT] = '{
        32'h00000000, 32'h0000000f, 32'h000000ff, 32'h00000fff, 32'h0000ffff,
        32'h000fffff, 32'h00ffffff, 32'h0fffffff, 32'heeeeeeee, 32'hcccccccc,
        32'h88888888, 32'h0000cccc, 32'h00003333, 32'hcccc0000, 32'hcccc3333,
        32'h33330000, 32'h000ff000, 32'h66666666, 32'h00077666, 32'h000ee666,
        32'h66677000, 32'h666ee000, 32'h66677666, 32'h666ee666, 32'h000ff666,
        32'h666ff000, 32'h666ff666, 32'h000cc000, 32'h00066000, 32'h00033000,
        32'h00066000, 32'h06600660, 32'h000f0000, 32'h0000f000, 32'h44444444,
        32'h22222222, 32'h000e0000, 32'h0000e000, 32'h44440000, 32'h22220000,
        32'h00030000, 32'h00003000, 32'h00004444, 32'h00002222, 32'h44444444,
        32'h22222222, 32'h0f000000, 32'h00f00000, 32'h00000f00, 32'h000000f0,
        32'h00066000};

    logic [20:0] code_rom[MASK_COUNT] = '{
        21'h000a0, 21'h02581, 21'h02582, 21'h02583, 21'h02584, 21'h02585,
        21'h02586, 21'h02587, 21'h0258a, 21'h0258c, 21'h0258e, 21'h02596,
        21'h02597, 21'h02598, 21'h0259a, 21'h0259d, 21'h02501, 21'h02503,
        21'h0250f, 21'h02513, 21'h02517, 21'h0251b, 21'h02523, 21'h0252b,
        21'h02533, 21'h0253b, 21'h0254b, 21'h02578, 21'h02579, 21'h0257a,
        21'h0257b, 21'h0254f, 21'h02500, 21'h02500, 21'h02502, 21'h02502,
        21'h02574, 21'h02574, 21'h02575, 21'h02575, 21'h02576, 21'h02576,
        21'h02577, 21'h02577, 21'h023a2, 21'h023a5, 21'h023ba, 21'h023bb,
        21'h023bc, 21'h023bd, 21'h025aa};

    glyph_block_matcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .pixel  (pixel),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #2 clk = ~clk;

    // Scores every mask against the stored cell; the first lowest error wins.
    function automatic gbm_pkg::result_t best_glyph_for_cell();
        gbm_pkg::result_t r;
        int best_err;
        int best_idx;
        logic [23:0] best_col[2];
        int sums[2][3];
        int cnt[2];
        logic [23:0] col[2];
        int err;
        int b;
        int d;
        logic [20:0] cp;
        best_err = 'h7fffff;
        best_idx = 0;
        best_col[0] = '0;
        best_col[1] = '0;
        for (int g = 0; g < MASK_COUNT; g++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                cnt[s] = 0;
                for (int c = 0; c < 3; c++)
                    sums[s][c] = 0;
            end
            for (int k = 0; k < 32; k++)
            begin
                b = mask_rom[g][31 - k];
                cnt[b]++;
                for (int c = 0; c < 3; c++)
                    sums[b][c] += cell_pixels[k][16 - 8 * c +: 8];
            end
            for (int s = 0; s < 2; s++)
            begin
                col[s] = '0;
                if (cnt[s] != 0)
                    for (int c = 0; c < 3; c++)
                        col[s][16 - 8 * c +: 8] = 8'(sums[s][c] / cnt[s]);
            end
            err = 0;
            for (int k = 0; k < 32; k++)
            begin
                b = mask_rom[g][31 - k];
                for (int c = 0; c < 3; c++)
                begin
                    d = int'(col[b][16 - 8 * c +: 8]) - int'(cell_pixels[k][16 - 8 * c +: 8]);
                    err += d * d;
                end
            end
            if (err < best_err)
            begin
                best_err = err;
                best_idx = g;
                best_col = col;
            end
        end
        cp = code_rom[best_idx];
        r.glyph_codepoint = cp;
        if (cp <= 21'h7f)
        begin
            r.utf8_bytes = {25'd0, cp[6:0]};
            r.utf8_length = 3'd1;
        end
        else if (cp <= 21'h7ff)
        begin
            r.utf8_bytes = {16'd0, 8'hc0 | cp[10:6], 8'h80 | cp[5:0]};
            r.utf8_length = 3'd2;
        end
        else if (cp <= 21'hffff)
        begin
            r.utf8_bytes = {8'd0, 8'he0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
            r.utf8_length = 3'd3;
        end
        else
        begin
            r.utf8_bytes = {8'hf0 | cp[20:18], 8'h80 | cp[17:12], 8'h80 | cp[11:6],
                            8'h80 | cp[5:0]};
            r.utf8_length = 3'd4;
        end
        r.clear_color = best_col[0];
        r.ink_color = best_col[1];
        r.match_error = best_err[22:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // Drives one pixel word and holds it until the block takes it.
    task automatic send_pixel(input logic [23:0] value);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        pixel <= value;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        cell_pixels[cell_fill] = value;
        pixels_sent++;
        if (cell_fill == 31)
        begin
            pending_results.push_back(best_glyph_for_cell());
            cell_fill = 0;
        end
        else
            cell_fill++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            pixel <= 24'($urandom);
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic send_two_color_cell(input logic [31:0] shape, input logic [23:0] ink,
                                       input logic [23:0] paper);
        for (int k = 0; k < 32; k++)
            send_pixel(shape[31 - k] ? ink : paper);
    endtask

    task automatic test_flat_cells();
        send_two_color_cell(32'h0, 24'h000000, 24'h000000);
        send_two_color_cell(32'h0, 24'hffffff, 24'hffffff);
        // A cell of black and white pixels drives both channel extremes in one search.
        send_two_color_cell(32'hcccccccc, 24'hffffff, 24'h000000);
    endtask

    task automatic test_glyph_shapes();
        for (int g = 1; g < MASK_COUNT; g += 7)
            send_two_color_cell(mask_rom[g], 24'($urandom), 24'($urandom));
    endtask

    task automatic test_random_cells();
        int kind;
        logic [31:0] shape;
        logic [23:0] ink;
        logic [23:0] paper;
        logic [23:0] noise;
        for (int n = 0; n < CELLS_RANDOM; n++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 3);
            shape = (kind == 3) ? $urandom : mask_rom[$urandom_range(0, MASK_COUNT - 1)];
            ink = 24'($urandom);
            paper = 24'($urandom);
            for (int k = 0; k < 32; k++)
            begin
                noise = {3{$urandom_range(0, 15) == 0 ? 8'($urandom) : 8'd0}};
                case (kind)
                    0: send_pixel(24'($urandom));
                    1: send_pixel(shape[31 - k] ? ink : paper);
                    default: send_pixel((shape[31 - k] ? ink : paper) ^ (noise & 24'h0f0f0f));
                endcase
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, result);
                error_count++;
            end
            else
            begin
                gbm_pkg::result_t want;
                want = pending_results.pop_front();
                if (want.glyph_codepoint !== result.glyph_codepoint)
                    $display("%0t: codepoint expected %h actual %h", $time,
                             want.glyph_codepoint, result.glyph_codepoint);
                if (want.utf8_bytes !== result.utf8_bytes)
                    $display("%0t: utf8 bytes expected %h actual %h", $time,
                             want.utf8_bytes, result.utf8_bytes);
                if (want.utf8_length !== result.utf8_length)
                    $display("%0t: utf8 length expected %0d actual %0d", $time,
                             want.utf8_length, result.utf8_length);
                if (want.clear_color !== result.clear_color)
                    $display("%0t: clear color expected %h actual %h", $time,
                             want.clear_color, result.clear_color);
                if (want.ink_color !== result.ink_color)
                    $display("%0t: ink color expected %h actual %h", $time,
                             want.ink_color, result.ink_color);
                if (want.match_error !== result.match_error)
                    $display("%0t: match error expected %0d actual %0d", $time,
                             want.match_error, result.match_error);
                if (want !== result)
                    error_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy && rst_n) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_flat_cells();
        test_glyph_shapes();
        test_random_cells();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        $display("Sent %0d pixels in %0d cells and checked %0d result words.",
                 pixels_sent, pixels_sent / 32, results_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gbm_pkg.sv
rtl/glyph_block_matcher.sv
bench/testbench.sv
